// ===== design/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// dll_pkg: shared types and constants for the doubly linked list engine
// Command and status codes, payload structs and the front-to-back record.
// ----------------------------------------------------------------------------
package dll_pkg;

	localparam int unsigned NODES_DEF      = 256;
	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam int unsigned CMD_W          = 3;
	localparam int unsigned VAL_W          = 32;
	localparam int unsigned CNT_W          = 9;
	localparam int unsigned ST_W           = 2;

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIRST    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LAST     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PREV     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE    = 3'd7;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_END   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_NOCUR = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] value_in;
	} dll_in_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] value_out;
		logic [CNT_W-1:0] entry_count;
	} dll_out_t;

endpackage

// ===== design/doubly_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_engine: bounded doubly linked list with a cursor
// Command queue in front, list sequencer with node memories behind.
// ----------------------------------------------------------------------------
// channel  | handshake      | payload
// command  | push / full    | cmd_in  (command, value_in)
// result   | pop / empty    | res_out (status, value_out, entry_count)
// A command passes through the sequencer steps take, read, execute and
// link fix; a successful next or prev returns through read and execute
// for a second, registered node memory read. No clearing pass after reset.
// The result register must be popped before the next command starts.
module doubly_linked_list_engine
	import dll_pkg::*;
#(
	parameter int unsigned NODES      = NODES_DEF,
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  dll_in_t  cmd_in,
	output logic     empty,
	input  logic     pop,
	output dll_out_t res_out
);

	logic    cmd_valid, cmd_take;
	dll_in_t cmd_beat;

	dll_front #(.DEPTH(4)) u_front (
		.clk, .arst_n, .push, .full, .in_beat(cmd_in),
		.cmd_valid, .cmd_beat, .cmd_take
	);

	dll_back #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_beat, .cmd_take,
		.empty, .pop, .out_beat(res_out)
	);

endmodule

// ===== design/dll_front.sv =====
// ----------------------------------------------------------------------------
// dll_front: command intake queue
// Accepts command beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module dll_front
	import dll_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  dll_in_t in_beat,
	output logic    cmd_valid,
	output dll_in_t cmd_beat,
	input  logic    cmd_take
);

	localparam int unsigned AW = $clog2(DEPTH);

	dll_in_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            do_push, do_pop;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd_beat  = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + AW'(1);
			if (do_pop)  rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

// ===== design/dll_back.sv =====
// ----------------------------------------------------------------------------
// dll_back: list sequencer
// Carries out one command at a time against the node memories and
// places its result in an output register.
// ----------------------------------------------------------------------------
module dll_back
	import dll_pkg::*;
#(
	parameter int unsigned NODES      = NODES_DEF,
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  dll_in_t  cmd_beat,
	output logic     cmd_take,
	output logic     empty,
	input  logic     pop,
	output dll_out_t out_beat
);

	localparam int unsigned AW = $clog2(NODES);
	localparam int unsigned PW = $clog2(NODES + 1);
	localparam logic [PW-1:0] NIL = PW'(NODES);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_FIX   = 4'b1000
	} state_t;

	logic [VALUE_BITS-1:0] val_mem [NODES];
	logic [PW-1:0]         fwd_mem [NODES];
	logic [PW-1:0]         bwd_mem [NODES];

	state_t              state_q;
	dll_in_t             cmd_q;
	logic [PW-1:0]       head_q, tail_q, cur_q, free_q, fresh_q, used_q;
	logic [AW-1:0]       addr_q;
	logic [VALUE_BITS-1:0] rval_q;
	logic [PW-1:0]       rfwd_q, rbwd_q;
	logic                fwd_fix_en_q, bwd_fix_en_q;
	logic [AW-1:0]       fwd_fix_addr_q, bwd_fix_addr_q;
	logic [PW-1:0]       fwd_fix_data_q, bwd_fix_data_q;
	logic                out_v_q;
	dll_out_t            out_q;
	logic [PW-1:0]       nb;
	logic [PW-1:0]       node_n;
	logic                is_ins;

	function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
		slot = (p < NIL) ? p[AW-1:0] : '0;
	endfunction

	assign empty    = !out_v_q;
	assign out_beat = out_q;
	assign cmd_take = (state_q == S_IDLE) && cmd_valid && !out_v_q;
	assign is_ins   = (cmd_q.command == CMD_INS_HEAD) || (cmd_q.command == CMD_INS_TAIL);
	assign nb       = (cmd_q.command == CMD_PREV) ? rbwd_q : rfwd_q;
	assign node_n   = (free_q != NIL) ? PW'(slot(free_q)) : fresh_q;

	always_ff @(posedge clk) begin
		rval_q <= val_mem[addr_q];
		rfwd_q <= fwd_mem[addr_q];
		rbwd_q <= bwd_mem[addr_q];
		if (state_q == S_EXEC) begin
			if (is_ins && used_q < NIL) begin
				val_mem[node_n[AW-1:0]] <= VALUE_BITS'(cmd_q.value_in);
				fwd_mem[node_n[AW-1:0]] <=
					(cmd_q.command == CMD_INS_HEAD) ? head_q : NIL;
				bwd_mem[node_n[AW-1:0]] <=
					(cmd_q.command == CMD_INS_HEAD) ? NIL : tail_q;
			end else if (cmd_q.command == CMD_REMOVE && used_q != '0 && cur_q != NIL) begin
				fwd_mem[addr_q] <= free_q;
			end
		end
		if (state_q == S_FIX) begin
			if (fwd_fix_en_q) fwd_mem[fwd_fix_addr_q] <= fwd_fix_data_q;
			if (bwd_fix_en_q) bwd_mem[bwd_fix_addr_q] <= bwd_fix_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= NIL;
			tail_q       <= NIL;
			cur_q        <= NIL;
			free_q       <= NIL;
			fresh_q      <= '0;
			used_q       <= '0;
			out_v_q      <= 1'b0;
			fwd_fix_en_q <= 1'b0;
			bwd_fix_en_q <= 1'b0;
		end else begin
			if (pop && out_v_q) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cmd_q <= cmd_beat;
						case (cmd_beat.command)
							CMD_FIRST:              addr_q <= slot(head_q);
							CMD_LAST:               addr_q <= slot(tail_q);
							CMD_INS_HEAD, CMD_INS_TAIL: addr_q <= slot(free_q);
							default:                addr_q <= slot(cur_q);
						endcase
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					out_q.status    <= ST_OK;
					out_q.value_out <= '0;
					fwd_fix_en_q    <= 1'b0;
					bwd_fix_en_q    <= 1'b0;
					state_q         <= S_FIX;
					case (cmd_q.command)
						CMD_INS_HEAD, CMD_INS_TAIL: begin
							if (used_q >= NIL) begin
								out_q.status <= ST_FULL;
							end else begin
								if (free_q != NIL) free_q <= rfwd_q;
								else               fresh_q <= fresh_q + PW'(1);
								used_q <= used_q + PW'(1);
								if (cmd_q.command == CMD_INS_HEAD) begin
									bwd_fix_en_q   <= (head_q != NIL);
									bwd_fix_addr_q <= slot(head_q);
									bwd_fix_data_q <= node_n;
									if (head_q == NIL) tail_q <= node_n;
									head_q <= node_n;
								end else begin
									fwd_fix_en_q   <= (tail_q != NIL);
									fwd_fix_addr_q <= slot(tail_q);
									fwd_fix_data_q <= node_n;
									if (tail_q == NIL) head_q <= node_n;
									tail_q <= node_n;
								end
							end
						end
						CMD_FIRST, CMD_LAST: begin
							if (used_q == '0) begin
								out_q.status <= ST_END;
							end else begin
								cur_q <= PW'(addr_q);
								out_q.value_out <= VAL_W'(rval_q);
							end
						end
						CMD_NEXT, CMD_PREV: begin
							if (cur_q == NIL) begin
								out_q.status <= ST_NOCUR;
							end else if (nb == NIL) begin
								out_q.status <= ST_END;
							end else begin
								cur_q   <= nb;
								addr_q  <= slot(nb);
								state_q <= S_READ;
								cmd_q.command <= CMD_FIRST;
							end
						end
						CMD_REMOVE: begin
							if (used_q == '0) begin
								out_q.status <= ST_END;
							end else if (cur_q == NIL) begin
								out_q.status <= ST_NOCUR;
							end else begin
								out_q.value_out <= VAL_W'(rval_q);
								if (rbwd_q != NIL) begin
									fwd_fix_en_q   <= 1'b1;
									fwd_fix_addr_q <= slot(rbwd_q);
									fwd_fix_data_q <= rfwd_q;
								end else begin
									head_q <= rfwd_q;
								end
								if (rfwd_q != NIL) begin
									bwd_fix_en_q   <= 1'b1;
									bwd_fix_addr_q <= slot(rfwd_q);
									bwd_fix_data_q <= rbwd_q;
								end else begin
									tail_q <= rbwd_q;
								end
								free_q <= PW'(addr_q);
								used_q <= used_q - PW'(1);
								cur_q  <= NIL;
							end
						end
						default: ;
					endcase
				end
				S_FIX: begin
					fwd_fix_en_q <= 1'b0;
					bwd_fix_en_q <= 1'b0;
					state_q      <= S_IDLE;
					out_q.entry_count <= CNT_W'(used_q);
					out_v_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/dll_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_checker: list predictor and result scoreboard
// Watches accepted command and result beats, runs its own linked list model
// and compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dll_checker
	import dll_pkg::*;
#(
	parameter int unsigned NODES = NODES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  logic     full,
	input  dll_in_t  cmd_in,
	input  logic     empty,
	input  logic     pop,
	input  dll_out_t res_out,
	output int       fail_count,
	output int       pending
);

	localparam int NIL = NODES;

	logic [VAL_W-1:0] lst_val  [NODES];
	int               lst_fwd  [NODES];
	int               lst_bwd  [NODES];
	int               head_idx, tail_idx, cur_idx, free_idx, fresh_used, used;
	dll_out_t         expected_q[$];

	assign pending = expected_q.size();

	function automatic int take_slot();
		int n;
		if (free_idx != NIL) begin
			n = free_idx;
			free_idx = lst_fwd[n];
			return n;
		end
		if (fresh_used < NODES) begin
			n = fresh_used;
			fresh_used++;
			return n;
		end
		return NIL;
	endfunction

	function automatic dll_out_t apply_command(dll_in_t c);
		dll_out_t r;
		int n, nb, pv;
		r = '0;
		r.status = ST_OK;
		case (c.command)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				n = (used >= NODES) ? NIL : take_slot();
				if (n == NIL) r.status = ST_FULL;
				else begin
					lst_val[n] = c.value_in;
					if (c.command == CMD_INS_HEAD) begin
						lst_bwd[n] = NIL;
						lst_fwd[n] = head_idx;
						if (head_idx != NIL) lst_bwd[head_idx] = n;
						else tail_idx = n;
						head_idx = n;
					end else begin
						lst_fwd[n] = NIL;
						lst_bwd[n] = tail_idx;
						if (tail_idx != NIL) lst_fwd[tail_idx] = n;
						else head_idx = n;
						tail_idx = n;
					end
					used++;
				end
			end
			CMD_FIRST, CMD_LAST: begin
				if (used == 0) r.status = ST_END;
				else begin
					cur_idx = (c.command == CMD_FIRST) ? head_idx : tail_idx;
					r.value_out = lst_val[cur_idx];
				end
			end
			CMD_NEXT, CMD_PREV: begin
				if (cur_idx == NIL) r.status = ST_NOCUR;
				else begin
					nb = (c.command == CMD_NEXT) ? lst_fwd[cur_idx] : lst_bwd[cur_idx];
					if (nb == NIL) r.status = ST_END;
					else begin
						cur_idx = nb;
						r.value_out = lst_val[nb];
					end
				end
			end
			CMD_REMOVE: begin
				if (used == 0) r.status = ST_END;
				else if (cur_idx == NIL) r.status = ST_NOCUR;
				else begin
					r.value_out = lst_val[cur_idx];
					pv = lst_bwd[cur_idx];
					nb = lst_fwd[cur_idx];
					if (pv != NIL) lst_fwd[pv] = nb;
					else head_idx = nb;
					if (nb != NIL) lst_bwd[nb] = pv;
					else tail_idx = pv;
					lst_fwd[cur_idx] = free_idx;
					free_idx = cur_idx;
					used--;
					cur_idx = NIL;
				end
			end
			default: ;
		endcase
		r.entry_count = used[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dll_out_t exp_beat;
		if (!arst_n) begin
			head_idx   = NIL;
			tail_idx   = NIL;
			cur_idx    = NIL;
			free_idx   = NIL;
			fresh_used = 0;
			used       = 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (!empty && pop) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no prediction waiting");
					fail_count++;
				end else begin
					exp_beat = expected_q.pop_front();
					if (res_out.status !== exp_beat.status) begin
						$error("status expected %0d actual %0d", exp_beat.status, res_out.status);
						fail_count++;
					end
					if (res_out.value_out !== exp_beat.value_out) begin
						$error("value_out expected %h actual %h",
							exp_beat.value_out, res_out.value_out);
						fail_count++;
					end
					if (res_out.entry_count !== exp_beat.entry_count) begin
						$error("entry_count expected %0d actual %0d",
							exp_beat.entry_count, res_out.entry_count);
						fail_count++;
					end
				end
			end
			if (push && !full)
				expected_q.push_back(apply_command(cmd_in));
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the doubly linked list engine
// Drives directed and random command sequences in bursts, stalls the result
// side on its own pattern and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_top;
	import dll_pkg::*;

	localparam int NODES      = NODES_DEF;
	localparam int IDLE_LIMIT = 5000;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	dll_in_t  cmd_in;
	logic     empty;
	logic     pop;
	dll_out_t res_out;
	int       fail_count;
	int       pending;
	bit       stim_done;
	bit       hold_off;
	int       idle_cycles;

	doubly_linked_list_engine #(.NODES(NODES)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd_in(cmd_in),
		.empty(empty), .pop(pop), .res_out(res_out)
	);

	dll_checker #(.NODES(NODES)) i_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd_in(cmd_in),
		.empty(empty), .pop(pop), .res_out(res_out),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v);
		push <= 1'b1;
		cmd_in.command <= c;
		cmd_in.value_in <= v;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		int gap;
		gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			cmd_in.value_in <= $urandom();
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random(input int ins_weight);
		int pick;
		logic [CMD_W-1:0] c;
		pick = $urandom_range(0, 99);
		if (pick < ins_weight) c = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
		else if (pick < ins_weight + 25) c = $urandom_range(0, 1) ? CMD_NEXT : CMD_PREV;
		else if (pick < ins_weight + 35) c = $urandom_range(0, 1) ? CMD_FIRST : CMD_LAST;
		else if (pick < 97) c = CMD_REMOVE;
		else c = CMD_SPARE;
		send_beat(c, rand_value());
	endtask

	initial begin
		int burst;
		arst_n = 1'b0;
		push = 1'b0;
		cmd_in = '0;
		stim_done = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// empty-list corners, then short directed inserts, walks and removes
		send_beat(CMD_FIRST, '0);
		send_beat(CMD_LAST, '0);
		send_beat(CMD_NEXT, '0);
		send_beat(CMD_PREV, '0);
		send_beat(CMD_REMOVE, '0);
		send_beat(CMD_SPARE, '1);
		send_beat(CMD_INS_HEAD, 32'hFFFF_FFFF);
		send_beat(CMD_INS_TAIL, 32'h0000_0000);
		send_beat(CMD_INS_HEAD, 32'hA5A5_5A5A);
		send_beat(CMD_REMOVE, '0);
		send_beat(CMD_FIRST, '0);
		send_beat(CMD_PREV, '0);
		send_beat(CMD_NEXT, '0);
		send_beat(CMD_NEXT, '0);
		send_beat(CMD_NEXT, '0);
		send_beat(CMD_LAST, '0);
		send_beat(CMD_REMOVE, '0);
		send_beat(CMD_NEXT, '0);
		send_beat(CMD_REMOVE, '0);
		// fill to capacity and overflow
		for (int i = 0; i < NODES + 2; i++) begin
			send_random(100);
			if (i % 16 == 0) pause_sender();
		end
		send_beat(CMD_FIRST, '0);
		for (int i = 0; i < 40; i++) begin
			send_beat(CMD_REMOVE, '0);
			send_beat(($urandom_range(0, 1)) ? CMD_FIRST : CMD_LAST, '0);
		end
		for (int i = 0; i < 190; ) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				send_random(i < 100 ? 30 : 45);
				i++;
			end
			pause_sender();
		end
		push <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (60) @(negedge clk);
		hold_off = 1'b1;
		repeat (400) @(negedge clk);
		hold_off = 1'b0;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= !hold_off && ($urandom_range(0, 9) < ((($time / 2000) % 3 == 0) ? 10 : 6));
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		wait (stim_done);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/dll_pkg.sv
design/dll_front.sv
design/dll_back.sv
design/doubly_linked_list_engine.sv
bench/dll_checker.sv
bench/tb_top.sv
